### rtl/edf_task_dispatcher_core_macros.svh
// Assertion macros for the earliest-deadline-first dispatcher.
// The macros use the clk and rst_n names of the including module.
`ifndef EDF_TASK_DISPATCHER_CORE_MACROS_SVH
`define EDF_TASK_DISPATCHER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define EDF_CHK_NOW(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("dispatcher check failed");
`define EDF_CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dispatcher sequencing check failed");
`else
`define EDF_CHK_NOW(label, cond)
`define EDF_CHK_NEXT(label, ante, cons)
`endif
`endif

### rtl/edf_pkg.sv
// Shared types and constants of the earliest-deadline-first dispatcher.
// No dependencies; used by edf_cfg_regs and edf_task_dispatcher_core.
`default_nettype none
package edf_pkg;

  localparam int unsigned MAX_TASKS = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TASK_W    = 2;

  // Register index map: periods first, relative deadlines after them.
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TASK0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_DL_TASK0 = 3'd4;

  localparam logic [MAX_TASKS-1:0][CFG_W-1:0] PERIOD_RST = {16'd0, 16'd2000, 16'd1500, 16'd1000};
  localparam logic [MAX_TASKS-1:0][CFG_W-1:0] REL_DL_RST = {16'd0, 16'd2000, 16'd1500, 16'd1000};

  typedef struct packed {
    logic [MAX_TASKS-1:0][CFG_W-1:0] period;
    logic [MAX_TASKS-1:0][CFG_W-1:0] rel_dl;
  } cfg_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage
`default_nettype wire

### rtl/edf_cfg_regs.sv
// Configuration register bank: task periods and relative deadlines.
// Depends on edf_pkg.
`default_nettype none
module edf_cfg_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [edf_pkg::CFG_W-1:0]     cfg_wdata,
  output edf_pkg::cfg_t                      cfg
);
  import edf_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      // The upper index bit selects the deadline half of the map.
      if (cfg_index[CFG_IDX_W-1] == CFG_REL_DL_TASK0[CFG_IDX_W-1]) begin
        cfg_nxt.rel_dl[cfg_index[TASK_W-1:0]] = cfg_wdata;
      end else begin
        cfg_nxt.period[cfg_index[TASK_W-1:0]] = cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.period <= PERIOD_RST;
      cfg_r.rel_dl <= REL_DL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### rtl/edf_task_dispatcher_core.sv
// Channel  | Direction | Ports                                    | Handshake
// in       | input     | in_current_time                          | in_valid / in_stall
// out      | output    | out_dispatch_valid, out_dispatched_task  | out_valid / out_stall
// cfg      | input     | cfg_index, cfg_wdata                     | cfg_we
// Between one accepted word and the next, the block does one release-time memory
// read per task, one trailing compare and one write-back, then returns to idle,
// where the next word is taken; no new word is taken before then.
// The single-port release-time memory and its registered read set this sequence.
// Reset is synchronous; release times read as zero until first written.
// A result waiting on out_stall holds the write-back cycle; input is taken again after it.
// Depends on edf_pkg, edf_cfg_regs and edf_task_dispatcher_core_macros.svh.
`default_nettype none
module edf_task_dispatcher_core #(
  parameter int unsigned NUM_TASKS = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [edf_pkg::TIME_W-1:0]    in_current_time,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic                          out_dispatch_valid,
  output      logic [edf_pkg::TASK_W-1:0]    out_dispatched_task,
  input  wire logic                          cfg_we,
  input  wire logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [edf_pkg::CFG_W-1:0]     cfg_wdata
);
  import edf_pkg::*;
  `include "edf_task_dispatcher_core_macros.svh"

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);

  cfg_t cfg;

  edf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Release-time store: synchronous memory plus per-entry valid bits for the reset value.
  logic [TIME_W-1:0]    mem [NUM_TASKS];
  logic [NUM_TASKS-1:0] vld_r;
  logic [TIME_W-1:0]    rd_data_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic                 cmp_en_r;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    rd_addr_r, rd_addr_nxt;
  logic [TIME_W-1:0]   now_r;
  logic                found_r, found_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [TIME_W:0]     best_dl_r, best_dl_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                res_found_r;
  logic [TASK_W-1:0]   res_task_r;

  logic                in_acc;
  logic                out_free;
  logic                wb_go;
  logic [TIME_W-1:0]   rd_rel;
  logic [TASK_W-1:0]   rd_task;
  logic [TASK_W-1:0]   best_task;
  logic [TIME_W:0]     rd_dl;
  logic                take;
  logic [TIME_W-1:0]   new_release;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign wb_go    = (state_r == S_DONE) && out_free;

  assign rd_rel  = rd_vld_r ? rd_data_r : '0;
  assign rd_task = TASK_W'(rd_idx_r);
  assign rd_dl   = {1'b0, rd_rel} + {{(TIME_W + 1 - CFG_W){1'b0}}, cfg.rel_dl[rd_task]};
  // Strict less-than over an ascending scan keeps the lower index on a tie.
  assign take    = cmp_en_r && (now_r >= rd_rel) && (!found_r || (rd_dl < best_dl_r));

  assign best_task   = TASK_W'(best_idx_r);
  assign new_release = now_r + {{(TIME_W - CFG_W){1'b0}}, cfg.period[best_task]};

  always_comb begin
    state_nxt    = state_r;
    rd_addr_nxt  = rd_addr_r;
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_dl_nxt  = best_dl_r;
    if (take) begin
      found_nxt    = 1'b1;
      best_idx_nxt = rd_idx_r;
      best_dl_nxt  = rd_dl;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt   = S_SCAN;
          rd_addr_nxt = '0;
          found_nxt   = 1'b0;
        end
      end
      S_SCAN: begin
        if (rd_addr_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end else begin
          rd_addr_nxt = rd_addr_r + IDX_W'(1);
        end
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (wb_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cmp_en_r    <= 1'b0;
      found_r     <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_en_r    <= (state_r == S_SCAN);
      found_r     <= found_nxt;
      if (wb_go && found_r) begin
        vld_r[best_idx_r] <= 1'b1;
      end
    end
  end

  // The write-back lands before the idle state, which comes ahead of the next word's first
  // read, so no access to an entry can overlap another and no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) begin
      rd_data_r <= mem[rd_addr_r];
      rd_vld_r  <= vld_r[rd_addr_r];
      rd_idx_r  <= rd_addr_r;
    end
    if (wb_go && found_r) begin
      mem[best_idx_r] <= new_release;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    best_idx_r <= best_idx_nxt;
    best_dl_r  <= best_dl_nxt;
    if (in_acc) begin
      now_r <= in_current_time;
    end
    if (wb_go) begin
      res_found_r <= found_r;
      res_task_r  <= found_r ? best_task : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_dispatch_valid  = res_found_r;
  assign out_dispatched_task = res_task_r;

  `EDF_CHK_NEXT(a_accept_starts_scan, in_acc, (state_r == S_SCAN) && !found_r)
  `EDF_CHK_NOW(a_cmp_in_scan, !cmp_en_r || (state_r == S_SCAN) || (state_r == S_LAST))
  `EDF_CHK_NOW(a_idle_task_zero, !out_valid_r || res_found_r || (res_task_r == '0))
  `EDF_CHK_NEXT(a_wb_sets_valid, wb_go && found_r, vld_r[$past(best_idx_r)])

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for edf_task_dispatcher_core: drives scheduler ticks, models
// earliest-deadline-first selection and release updates, and checks every dispatch word.
// Depends on edf_pkg and the dispatcher RTL only.
module tb;
  import edf_pkg::*;

  localparam int N_TASKS       = 3;
  localparam int SETTLE_CYCLES = 2 * (N_TASKS + 3) + 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RAND_PHASES   = 8;
  localparam int TICKS_PER_PHASE = 75;

  typedef enum int {
    TRAFFIC_FULL,
    TRAFFIC_SPARSE_SEND,
    TRAFFIC_SLOW_RECV,
    TRAFFIC_BOTH
  } traffic_t;

  typedef struct packed {
    logic              dispatch_valid;
    logic [TASK_W-1:0] dispatched_task;
  } dispatch_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [TIME_W-1:0]    in_current_time = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_dispatch_valid;
  logic [TASK_W-1:0]    out_dispatched_task;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow of the block: programmed settings and per-task release times.
  logic [CFG_W-1:0]  period_cfg [MAX_TASKS];
  logic [CFG_W-1:0]  rel_dl_cfg [MAX_TASKS];
  logic [TIME_W-1:0] release_at [N_TASKS];
  logic [CFG_W-1:0]  new_period [MAX_TASKS];
  logic [CFG_W-1:0]  new_rel_dl [MAX_TASKS];

  logic [TIME_W-1:0] tick_queue [$];
  dispatch_t         expected_dispatch [$];
  logic              in_took = 1'b0;
  int                send_idle_pct = 0;
  int                recv_stall_pct = 0;
  int                hold_req = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  logic [TIME_W-1:0] sched_time = '0;
  int unsigned       step_max = 1;

  edf_task_dispatcher_core #(.NUM_TASKS(N_TASKS)) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_current_time     (in_current_time),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dispatch_valid  (out_dispatch_valid),
    .out_dispatched_task (out_dispatched_task),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic flag_mismatch(input string msg);
    $display("%0t: dispatch error: %s", $time, msg);
    mismatch_count++;
  endtask

  // Picks the ready task with the earliest absolute deadline and moves its release.
  function automatic dispatch_t pick_earliest_deadline(input logic [TIME_W-1:0] now);
    dispatch_t         pick;
    logic [TIME_W:0]   deadline;
    logic [TIME_W:0]   best_deadline;
    pick = '0;
    best_deadline = '0;
    for (int i = 0; i < N_TASKS; i++) begin
      if (now >= release_at[i]) begin
        deadline = {1'b0, release_at[i]} + (TIME_W + 1)'(rel_dl_cfg[i]);
        if (!pick.dispatch_valid || deadline < best_deadline) begin
          pick.dispatch_valid  = 1'b1;
          pick.dispatched_task = TASK_W'(i);
          best_deadline        = deadline;
        end
      end
    end
    if (pick.dispatch_valid)
      release_at[pick.dispatched_task] = now + TIME_W'(period_cfg[pick.dispatched_task]);
    return pick;
  endfunction

  // Ticks mostly march forward; now and then they repeat, jump, sit near the
  // top of the range so release sums wrap, or land on the all-ones time.
  function automatic logic [TIME_W-1:0] next_tick();
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 4) begin
      return '1;
    end else if (roll < 8) begin
      sched_time = $urandom;
    end else if (roll < 11) begin
      sched_time = '1 - TIME_W'($urandom_range(3 * step_max, 0));
    end else if (roll >= 20) begin
      sched_time = sched_time + TIME_W'($urandom_range(step_max, 0));
    end
    return sched_time;
  endfunction

  task automatic set_traffic(input traffic_t mode);
    case (mode)
      TRAFFIC_FULL: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      TRAFFIC_SPARSE_SEND: begin
        send_idle_pct = 85;
        recv_stall_pct = 0;
      end
      TRAFFIC_SLOW_RECV: begin
        send_idle_pct = 0;
        recv_stall_pct = 85;
      end
      default: begin
        send_idle_pct = 12;
        recv_stall_pct = 12;
      end
    endcase
  endtask

  // Called at a falling edge with nothing in flight; writes all eight registers.
  task automatic apply_settings();
    for (int i = 0; i < MAX_TASKS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_PERIOD_TASK0 + CFG_IDX_W'(i);
      cfg_wdata <= new_period[i];
      period_cfg[i] = new_period[i];
      @(negedge clk);
    end
    for (int i = 0; i < MAX_TASKS; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_REL_DL_TASK0 + CFG_IDX_W'(i);
      cfg_wdata <= new_rel_dl[i];
      rel_dl_cfg[i] = new_rel_dl[i];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Waits until every tick has been taken and answered; the write-back of the
  // last word is done by then, and the task returns at a falling edge.
  task automatic drain();
    @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || expected_dispatch.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (tick_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_current_time <= tick_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stall, with an occasional long hold-off to back up the block.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    dispatch_t want;
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_dispatch.push_back(pick_earliest_deadline(in_current_time));
      if (out_valid && !out_stall) begin
        if (expected_dispatch.size() == 0) begin
          flag_mismatch($sformatf("word with nothing pending: valid=%0b task=%0d",
                                  out_dispatch_valid, out_dispatched_task));
        end else begin
          want = expected_dispatch.pop_front();
          if (out_dispatch_valid !== want.dispatch_valid)
            flag_mismatch($sformatf("dispatch_valid got %0b want %0b",
                                    out_dispatch_valid, want.dispatch_valid));
          if (out_dispatched_task !== want.dispatched_task)
            flag_mismatch($sformatf("dispatched_task got %0d want %0d",
                                    out_dispatched_task, want.dispatched_task));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned widest;
    for (int i = 0; i < MAX_TASKS; i++) begin
      period_cfg[i] = PERIOD_RST[i];
      rel_dl_cfg[i] = REL_DL_RST[i];
    end
    for (int i = 0; i < N_TASKS; i++)
      release_at[i] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Power-up settings: all tasks released at zero, then a tick with none
    // ready, the release boundary, and the all-ones time that wraps releases.
    @(posedge clk);
    set_traffic(TRAFFIC_FULL);
    tick_queue = {tick_queue, 32'd0, 32'd0, 32'd0, 32'd0, 32'd999, 32'd1000, 32'd1500,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    drain();

    // Equal deadlines for a tie, and zero periods that re-release at once.
    new_period = '{16'd0, 16'd0, 16'd300, 16'h5555};
    new_rel_dl = '{16'd500, 16'd500, 16'd500, 16'hAAAA};
    apply_settings();
    @(posedge clk);
    tick_queue = {tick_queue, 32'd5000, 32'd5000, 32'd5000, 32'd5001, 32'd5300, 32'd5300,
                  32'd6000};
    drain();

    // Largest periods with a zero deadline in the middle.
    new_period = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    new_rel_dl = '{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF};
    apply_settings();
    @(posedge clk);
    tick_queue = {tick_queue, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFE,
                  32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    drain();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        case (phase)
          1, 6: begin
            new_period[i] = CFG_W'($urandom_range(65535, 0));
            new_rel_dl[i] = CFG_W'($urandom_range(65535, 0));
          end
          2: begin
            new_period[i] = '0;
            new_rel_dl[i] = '0;
          end
          3: begin
            new_period[i] = '1;
            new_rel_dl[i] = '1;
          end
          5: begin
            new_period[i] = CFG_W'($urandom_range(2000, 1));
            new_rel_dl[i] = '0;
          end
          default: begin
            new_period[i] = CFG_W'($urandom_range(3000, 1));
            new_rel_dl[i] = CFG_W'($urandom_range(3000, 0));
          end
        endcase
      end
      apply_settings();
      widest = 0;
      for (int i = 0; i < N_TASKS; i++)
        if (32'(period_cfg[i]) > widest)
          widest = 32'(period_cfg[i]);
      step_max = widest / 2 + 2;

      @(posedge clk);
      set_traffic(traffic_t'(phase % 4));
      // Three all-ones ticks find every task ready; each dispatch sets a release of the period minus one, modulo 2^32.
      tick_queue = {tick_queue, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      sched_time = TIME_W'($urandom_range(500, 0));
      for (int k = 3; k < TICKS_PER_PHASE; k++)
        tick_queue.push_back(next_tick());
      if (phase == 4)
        hold_req++;
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
